// ===== rtl/pdd_pkg.sv =====
// Package for the P-DATA-TF deframer: item types, parse phases and codes.
// Used by every module of the deframer; depends on nothing.
package pdd_pkg;

    // Parse phase of the unit being received
    typedef enum logic [2:0] {
        PH_TYPE     = 3'd0,
        PH_RESERVED = 3'd1,
        PH_PDU_LEN  = 3'd2,
        PH_ITEM_LEN = 3'd3,
        PH_CTX      = 3'd4,
        PH_CTRL     = 3'd5,
        PH_FRAG     = 3'd6,
        PH_DONE     = 3'd7
    } t_phase;

    // Error codes carried in each result item
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SHORT = 2'd1;
    localparam logic [1:0] ERR_TYPE  = 2'd2;
    localparam logic [1:0] ERR_LEN   = 2'd3;

    // Protocol constants
    localparam logic [7:0]  TYPE_P_DATA     = 8'd4;
    localparam logic [31:0] ITEM_HDR_MIN    = 32'd6;
    localparam logic [31:0] ITEM_LEN_MIN    = 32'd2;
    localparam logic [2:0]  LEN_FIELD_BYTES = 3'd4;

    // One raw input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One deframed result
    typedef struct packed {
        logic       has_byte;
        logic [7:0] payload_byte;
        logic [7:0] context_id;
        logic       cmd_flag;
        logic       last_frag_flag;
        logic       fragment_start;
        logic       fragment_end;
        logic       pdu_end;
        logic [1:0] error_code;
    } t_out_item;

endpackage

// ===== rtl/pdd_in_reg.sv =====
// Input register of the deframer: holds one raw byte item for the parser.
// Depends on pdd_pkg for the input item type.
module pdd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pdd_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output pdd_pkg::t_in_item o_item
);

    logic              r_valid;
    pdd_pkg::t_in_item r_item;

    // Stall only while a held item is not being consumed
    assign o_stall = r_valid && !i_take;

    // Load a new item whenever the register is free or being emptied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/pdd_parser.sv =====
// Parse state and per-byte logic of the deframer: one byte handled per step.
// Depends on pdd_pkg for phases, codes, constants and item types.
module pdd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  pdd_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    output pdd_pkg::t_out_item o_res_item
);

    pdd_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_fbc, n_fbc;
    logic [31:0]     r_pdu_left, n_pdu_left;
    logic [31:0]     r_item_left, n_item_left;
    logic [31:0]     r_len_shift, n_len_shift;
    logic [7:0]      r_ctx, n_ctx;
    logic            r_cmd, n_cmd;
    logic            r_lastfrag, n_lastfrag;

    logic [31:0] w_len_next;
    logic [31:0] w_pdu_dec;
    logic [31:0] w_item_dec;
    logic [2:0]  w_fbc_inc;
    logic [7:0]  w_b;
    logic        w_res;
    logic        w_closed;
    logic [1:0]  w_err;
    logic        w_has;
    logic [7:0]  w_pb;
    logic        w_start;
    logic        w_end;
    logic        w_pend;

    assign w_b        = i_item.data_byte;
    assign w_len_next = {r_len_shift[23:0], w_b};
    assign w_pdu_dec  = r_pdu_left - 32'd1;
    assign w_item_dec = r_item_left - 32'd1;
    assign w_fbc_inc  = r_fbc + 3'd1;

    // Work out the next state and the result for the byte at the input
    always_comb begin
        n_phase     = r_phase;
        n_fbc       = r_fbc;
        n_pdu_left  = r_pdu_left;
        n_item_left = r_item_left;
        n_len_shift = r_len_shift;
        n_ctx       = r_ctx;
        n_cmd       = r_cmd;
        n_lastfrag  = r_lastfrag;
        w_res       = 1'b0;
        w_closed    = 1'b0;
        w_err       = pdd_pkg::ERR_NONE;
        w_has       = 1'b0;
        w_pb        = 8'd0;
        w_start     = 1'b0;
        w_end       = 1'b0;
        w_pend      = 1'b0;

        unique case (r_phase)
            pdd_pkg::PH_DONE: begin
                // ignore bytes until the last-byte marker
            end
            pdd_pkg::PH_TYPE: begin
                if (w_b != pdd_pkg::TYPE_P_DATA) begin
                    w_err = pdd_pkg::ERR_TYPE;
                end else begin
                    n_phase = pdd_pkg::PH_RESERVED;
                end
            end
            pdd_pkg::PH_RESERVED: begin
                n_phase     = pdd_pkg::PH_PDU_LEN;
                n_fbc       = 3'd0;
                n_len_shift = 32'd0;
            end
            pdd_pkg::PH_PDU_LEN: begin
                n_len_shift = w_len_next;
                n_fbc       = w_fbc_inc;
                if (w_fbc_inc >= pdd_pkg::LEN_FIELD_BYTES) begin
                    n_pdu_left  = w_len_next;
                    n_fbc       = 3'd0;
                    n_len_shift = 32'd0;
                    if (w_len_next == 32'd0) begin
                        w_res    = 1'b1;
                        w_pend   = 1'b1;
                        w_closed = 1'b1;
                        n_phase  = pdd_pkg::PH_DONE;
                    end else begin
                        n_phase = pdd_pkg::PH_ITEM_LEN;
                    end
                end
            end
            pdd_pkg::PH_ITEM_LEN: begin
                if (r_fbc == 3'd0 && r_pdu_left < pdd_pkg::ITEM_HDR_MIN) begin
                    w_err = pdd_pkg::ERR_LEN;
                end else begin
                    n_len_shift = w_len_next;
                    n_pdu_left  = w_pdu_dec;
                    n_fbc       = w_fbc_inc;
                    if (w_fbc_inc >= pdd_pkg::LEN_FIELD_BYTES) begin
                        if (w_len_next < pdd_pkg::ITEM_LEN_MIN ||
                            w_len_next > w_pdu_dec) begin
                            w_err = pdd_pkg::ERR_LEN;
                        end else begin
                            n_item_left = w_len_next;
                            n_phase     = pdd_pkg::PH_CTX;
                        end
                        n_fbc       = 3'd0;
                        n_len_shift = 32'd0;
                    end
                end
            end
            pdd_pkg::PH_CTX: begin
                n_ctx       = w_b;
                n_pdu_left  = w_pdu_dec;
                n_item_left = w_item_dec;
                n_phase     = pdd_pkg::PH_CTRL;
            end
            pdd_pkg::PH_CTRL: begin
                n_cmd       = w_b[0];
                n_lastfrag  = w_b[1];
                n_pdu_left  = w_pdu_dec;
                n_item_left = w_item_dec;
                if (w_item_dec == 32'd0) begin
                    // empty fragment
                    w_res    = 1'b1;
                    w_start  = 1'b1;
                    w_end    = 1'b1;
                    w_pend   = (w_pdu_dec == 32'd0);
                    w_closed = w_pend;
                    n_phase  = w_pend ? pdd_pkg::PH_DONE : pdd_pkg::PH_ITEM_LEN;
                    n_fbc    = 3'd0;
                end else begin
                    n_phase = pdd_pkg::PH_FRAG;
                    n_fbc   = 3'd1;
                end
            end
            pdd_pkg::PH_FRAG: begin
                w_start     = (r_fbc != 3'd0);
                n_pdu_left  = w_pdu_dec;
                n_item_left = w_item_dec;
                n_fbc       = 3'd0;
                w_end       = (w_item_dec == 32'd0);
                w_pend      = w_end && (w_pdu_dec == 32'd0);
                w_res       = 1'b1;
                w_has       = 1'b1;
                w_pb        = w_b;
                if (w_end) begin
                    w_closed    = w_pend;
                    n_phase     = w_pend ? pdd_pkg::PH_DONE : pdd_pkg::PH_ITEM_LEN;
                    n_len_shift = 32'd0;
                end
            end
            default: begin
                n_phase = pdd_pkg::PH_DONE;
            end
        endcase

        // Replace the result by the error form on a framing fault
        if (w_err != pdd_pkg::ERR_NONE) begin
            w_res    = 1'b1;
            w_closed = 1'b1;
            w_has    = 1'b0;
            w_pb     = 8'd0;
            w_start  = 1'b0;
            w_end    = 1'b0;
            w_pend   = 1'b0;
            n_phase  = pdd_pkg::PH_DONE;
        end

        // Flag a buffer that ends before the unit is complete
        if (i_item.last_byte && r_phase != pdd_pkg::PH_DONE && !w_closed) begin
            w_err = pdd_pkg::ERR_SHORT;
            if (!w_res) begin
                w_res = 1'b1;
            end
        end

        o_res_valid                   = w_res && (r_phase != pdd_pkg::PH_DONE);
        o_res_item.has_byte           = w_has;
        o_res_item.payload_byte       = w_pb;
        o_res_item.context_id         = n_ctx;
        o_res_item.cmd_flag           = n_cmd;
        o_res_item.last_frag_flag     = n_lastfrag;
        o_res_item.fragment_start     = w_start;
        o_res_item.fragment_end       = w_end;
        o_res_item.pdu_end            = w_pend;
        o_res_item.error_code         = w_err;

        // Rearm on the last byte of the buffer
        if (i_item.last_byte) begin
            n_phase     = pdd_pkg::PH_TYPE;
            n_fbc       = 3'd0;
            n_pdu_left  = 32'd0;
            n_item_left = 32'd0;
            n_len_shift = 32'd0;
            n_ctx       = 8'd0;
            n_cmd       = 1'b0;
            n_lastfrag  = 1'b0;
        end
    end

    // Advance the parse state once per consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pdd_pkg::PH_TYPE;
            r_fbc       <= 3'd0;
            r_pdu_left  <= 32'd0;
            r_item_left <= 32'd0;
            r_len_shift <= 32'd0;
            r_ctx       <= 8'd0;
            r_cmd       <= 1'b0;
            r_lastfrag  <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_fbc       <= n_fbc;
            r_pdu_left  <= n_pdu_left;
            r_item_left <= n_item_left;
            r_len_shift <= n_len_shift;
            r_ctx       <= n_ctx;
            r_cmd       <= n_cmd;
            r_lastfrag  <= n_lastfrag;
        end
    end

endmodule

// ===== rtl/pdd_out_reg.sv =====
// Result register of the deframer: holds one result item until it is taken.
// Depends on pdd_pkg for the result item type.
module pdd_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  pdd_pkg::t_out_item i_item,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_stall,
    output pdd_pkg::t_out_item o_item
);

    logic               r_valid;
    pdd_pkg::t_out_item r_item;

    // Free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/pdata_pdu_deframer.sv =====
// P-DATA-TF deframer, top level: input register, byte parser, result register.
// Depends on pdd_pkg, pdd_in_reg, pdd_parser and pdd_out_reg.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_item) takes one raw byte of
//   the unit per item, with last_byte marking the end of the received buffer.
//   Output channel (o_out_valid, i_out_stall, o_out_item) gives zero or one
//   result item per byte: fragment bytes with their item's context id and
//   control flags, fragment start/end marks, end of unit and error codes.
//   A result is offered once its byte has passed through the input register
//   and the parser and has been loaded into the result register, and can be
//   taken while i_out_stall is low.
//   Throughput: one byte per cycle while the receiver does not stall; the
//   per-byte parse is a 32-bit decrement and compare between the input and
//   result registers. A byte that gives no result still takes a parser step.
//   After an error or the end of the unit, bytes are dropped up to and
//   including the next one with last_byte set, which rearms the parser.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to expecting a type byte.
//   When the receiver stalls, the result is held; the input register takes
//   at most one more byte, then o_in_stall stays high until the result drains.
module pdata_pdu_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pdd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pdd_pkg::t_out_item o_out_item
);

    logic               w_q_valid;
    pdd_pkg::t_in_item  w_q_item;
    logic               w_out_ready;
    logic               w_fire;
    logic               w_res_valid;
    pdd_pkg::t_out_item w_res_item;

    // Consume the held byte when the result register can take its result
    assign w_fire = w_q_valid && w_out_ready;

    pdd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_take  (w_fire),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    pdd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_fire),
        .i_item      (w_q_item),
        .o_res_valid (w_res_valid),
        .o_res_item  (w_res_item)
    );

    pdd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_res_valid),
        .i_item  (w_res_item),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    // The parser never advances while a stalled result is still held
    a_no_step_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !w_fire)
        else $error("parser advanced while the result register was blocked");

    // A fragment byte result never carries a framing error
    a_byte_no_frame_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.has_byte) |->
        (o_out_item.error_code == pdd_pkg::ERR_NONE ||
         o_out_item.error_code == pdd_pkg::ERR_SHORT))
        else $error("fragment byte result with a framing error");

    // End of unit is never flagged together with an error
    a_pdu_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.pdu_end) |->
        (o_out_item.error_code == pdd_pkg::ERR_NONE))
        else $error("end of unit flagged with an error");

    // An empty fragment result both starts and ends its fragment
    a_empty_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.has_byte && o_out_item.fragment_start) |->
        o_out_item.fragment_end)
        else $error("empty fragment without an end mark");
`endif

endmodule

// ===== test/tb_top.sv =====
// Testbench for the P-DATA-TF deframer: feeds raw unit bytes, predicts each
// result as its byte is accepted and checks every result item in order.
// Depends on pdd_pkg and the pdata_pdu_deframer RTL.
module tb_top;

    localparam int N_BYTES    = 1100;
    localparam int QUIET_TAIL = 150;
    localparam int DRAIN_AT   = 700;
    localparam int HOLD_AFTER = 150;
    localparam int LONG_HOLD  = 120;
    localparam int SETTLE     = 8;
    localparam int LIMIT      = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    pdd_pkg::t_in_item  in_item;
    logic               out_valid;
    logic               out_stall;
    pdd_pkg::t_out_item out_item;

    // Stimulus and expectations
    logic [7:0]         unit_bytes[$];
    pdd_pkg::t_in_item  raw_bytes_q[$];
    pdd_pkg::t_out_item expected_results_q[$];
    int         byte_total;
    int         bytes_sent;
    int         results_seen;
    int         mismatches;
    int         cycles;
    int         send_gap;
    int         hold_left;
    bit         drain_wait;
    bit         drain_done;
    bit         long_hold_done;

    // Parser state of the predictor
    pdd_pkg::t_phase pr_phase;
    logic [2:0]  pr_count;
    logic [31:0] pr_unit_left;
    logic [31:0] pr_item_left;
    logic [31:0] pr_len;
    logic [7:0]  pr_ctx;
    logic        pr_cmd;
    logic        pr_lastfrag;

    pdata_pdu_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic void parser_clear();
        pr_phase     = pdd_pkg::PH_TYPE;
        pr_count     = '0;
        pr_unit_left = '0;
        pr_item_left = '0;
        pr_len       = '0;
        pr_ctx       = '0;
        pr_cmd       = 1'b0;
        pr_lastfrag  = 1'b0;
    endfunction

    // Build a result carrying the held item attributes
    function automatic pdd_pkg::t_out_item frame_result(input logic has, input logic [7:0] b,
                                                        input logic st, input logic en,
                                                        input logic pe,
                                                        input logic [1:0] err);
        pdd_pkg::t_out_item r;
        r.has_byte       = has;
        r.payload_byte   = b;
        r.context_id     = pr_ctx;
        r.cmd_flag       = pr_cmd;
        r.last_frag_flag = pr_lastfrag;
        r.fragment_start = st;
        r.fragment_end   = en;
        r.pdu_end        = pe;
        r.error_code     = err;
        return r;
    endfunction

    // Advance the predicted parser by one byte; return 1 when a result is due
    function automatic bit deframe_byte(input pdd_pkg::t_in_item it,
                                        output pdd_pkg::t_out_item res);
        bit         produced;
        bit         closed;
        logic [1:0] err;
        logic [7:0] b;
        logic       st;
        logic       en;
        logic       pe;
        produced = 1'b0;
        closed   = 1'b0;
        err      = pdd_pkg::ERR_NONE;
        b        = it.data_byte;
        res      = '0;
        // Drop everything after an end or an error until the buffer ends
        if (pr_phase == pdd_pkg::PH_DONE) begin
            if (it.last_byte)
                parser_clear();
            return 1'b0;
        end
        case (pr_phase)
            pdd_pkg::PH_TYPE: begin
                if (b != pdd_pkg::TYPE_P_DATA)
                    err = pdd_pkg::ERR_TYPE;
                else
                    pr_phase = pdd_pkg::PH_RESERVED;
            end
            pdd_pkg::PH_RESERVED: begin
                pr_phase = pdd_pkg::PH_PDU_LEN;
                pr_count = '0;
                pr_len   = '0;
            end
            pdd_pkg::PH_PDU_LEN: begin
                pr_len   = {pr_len[23:0], b};
                pr_count = pr_count + 3'd1;
                if (pr_count == pdd_pkg::LEN_FIELD_BYTES) begin
                    pr_unit_left = pr_len;
                    pr_count     = '0;
                    pr_len       = '0;
                    if (pr_unit_left == '0) begin
                        res      = frame_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                                                pdd_pkg::ERR_NONE);
                        produced = 1'b1;
                        closed   = 1'b1;
                        pr_phase = pdd_pkg::PH_DONE;
                    end else begin
                        pr_phase = pdd_pkg::PH_ITEM_LEN;
                    end
                end
            end
            pdd_pkg::PH_ITEM_LEN: begin
                // An item header must fit in what is left of the unit
                if (pr_count == '0 && pr_unit_left < pdd_pkg::ITEM_HDR_MIN) begin
                    err = pdd_pkg::ERR_LEN;
                end else begin
                    pr_len       = {pr_len[23:0], b};
                    pr_unit_left = pr_unit_left - 32'd1;
                    pr_count     = pr_count + 3'd1;
                    if (pr_count == pdd_pkg::LEN_FIELD_BYTES) begin
                        if (pr_len < pdd_pkg::ITEM_LEN_MIN || pr_len > pr_unit_left) begin
                            err = pdd_pkg::ERR_LEN;
                        end else begin
                            pr_item_left = pr_len;
                            pr_phase     = pdd_pkg::PH_CTX;
                        end
                        pr_count = '0;
                        pr_len   = '0;
                    end
                end
            end
            pdd_pkg::PH_CTX: begin
                pr_ctx       = b;
                pr_unit_left = pr_unit_left - 32'd1;
                pr_item_left = pr_item_left - 32'd1;
                pr_phase     = pdd_pkg::PH_CTRL;
            end
            pdd_pkg::PH_CTRL: begin
                pr_cmd       = b[0];
                pr_lastfrag  = b[1];
                pr_unit_left = pr_unit_left - 32'd1;
                pr_item_left = pr_item_left - 32'd1;
                if (pr_item_left == '0) begin
                    // Empty fragment: one marker result
                    pe       = (pr_unit_left == '0);
                    res      = frame_result(1'b0, 8'h00, 1'b1, 1'b1, pe, pdd_pkg::ERR_NONE);
                    produced = 1'b1;
                    closed   = pe;
                    pr_phase = pe ? pdd_pkg::PH_DONE : pdd_pkg::PH_ITEM_LEN;
                    pr_count = '0;
                end else begin
                    pr_phase = pdd_pkg::PH_FRAG;
                    pr_count = 3'd1;
                end
            end
            default: begin
                st           = (pr_count != '0);
                pr_unit_left = pr_unit_left - 32'd1;
                pr_item_left = pr_item_left - 32'd1;
                pr_count     = '0;
                en           = (pr_item_left == '0);
                pe           = en && (pr_unit_left == '0);
                res          = frame_result(1'b1, b, st, en, pe, pdd_pkg::ERR_NONE);
                produced     = 1'b1;
                if (en) begin
                    closed   = pe;
                    pr_phase = pe ? pdd_pkg::PH_DONE : pdd_pkg::PH_ITEM_LEN;
                    pr_len   = '0;
                end
            end
        endcase
        if (err != pdd_pkg::ERR_NONE) begin
            res      = frame_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, err);
            produced = 1'b1;
            closed   = 1'b1;
            pr_phase = pdd_pkg::PH_DONE;
        end
        // Buffer ended before the unit was complete
        if (it.last_byte) begin
            if (!closed) begin
                if (produced)
                    res.error_code = pdd_pkg::ERR_SHORT;
                else
                    res = frame_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, pdd_pkg::ERR_SHORT);
                produced = 1'b1;
            end
            parser_clear();
        end
        return produced;
    endfunction

    // Append one byte to the unit being built
    function automatic void add_byte(input logic [7:0] v);
        unit_bytes.insert(unit_bytes.size(), v);
    endfunction

    // Write a big-endian 32-bit field into the unit being built
    function automatic void set_word(input int at, input logic [31:0] v);
        unit_bytes[at]     = v[31:24];
        unit_bytes[at + 1] = v[23:16];
        unit_bytes[at + 2] = v[15:8];
        unit_bytes[at + 3] = v[7:0];
    endfunction

    // Build a well-formed unit of random items
    function automatic void build_unit(input int n_items, input int max_frag);
        int frag;
        int k;
        unit_bytes.delete();
        add_byte(pdd_pkg::TYPE_P_DATA);
        add_byte(8'($urandom));
        repeat (4) add_byte(8'h00);
        for (k = 0; k < n_items; k++) begin
            frag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, max_frag)
                                               : $urandom_range(0, 6);
            repeat (4) add_byte(8'h00);
            set_word(unit_bytes.size() - 4, 32'(frag + 2));
            add_byte(8'($urandom));
            add_byte(8'($urandom));
            repeat (frag) add_byte(8'($urandom));
        end
        set_word(2, 32'(unit_bytes.size() - 6));
    endfunction

    // Queue the unit's bytes, marking the byte at cut as the buffer's last
    function automatic void queue_unit(input int cut);
        pdd_pkg::t_in_item it;
        int                k;
        for (k = 0; k < unit_bytes.size(); k++) begin
            it.data_byte = unit_bytes[k];
            it.last_byte = (k == cut);
            raw_bytes_q.insert(raw_bytes_q.size(), it);
            if (k == cut)
                break;
        end
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycles, what, got, want);
        mismatches++;
    endtask

    // Sender: offer queued bytes, predict each one as it is accepted
    always @(posedge i_clk) begin : sender
        pdd_pkg::t_out_item res;
        bit                 holding;
        if (i_rst_n) begin
            holding = in_valid && in_stall;
            if (in_valid && !in_stall) begin
                if (deframe_byte(in_item, res))
                    expected_results_q.insert(expected_results_q.size(), res);
                bytes_sent++;
                if (bytes_sent == DRAIN_AT && !drain_done) begin
                    drain_wait = 1'b1;
                    drain_done = 1'b1;
                end
            end
            if (drain_wait && expected_results_q.size() == 0)
                drain_wait = 1'b0;
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (drain_wait || raw_bytes_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (raw_bytes_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_item  <= raw_bytes_q.pop_front();
                end
            end
        end
    end

    // Receiver stall: random bursts plus one long hold-off
    always @(posedge i_clk) begin : receiver_stall
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end else if (raw_bytes_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(0, 10);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        pdd_pkg::t_out_item want;
        if (i_rst_n && out_valid === 1'b1 && !out_stall) begin
            results_seen++;
            if (expected_results_q.size() == 0) begin
                flag_mismatch("result with none pending", int'(out_item), 0);
            end else begin
                want = expected_results_q.pop_front();
                if (out_item.has_byte !== want.has_byte)
                    flag_mismatch("has_byte", out_item.has_byte, want.has_byte);
                if (out_item.payload_byte !== want.payload_byte)
                    flag_mismatch("payload_byte", out_item.payload_byte, want.payload_byte);
                if (out_item.context_id !== want.context_id)
                    flag_mismatch("context_id", out_item.context_id, want.context_id);
                if (out_item.cmd_flag !== want.cmd_flag)
                    flag_mismatch("cmd_flag", out_item.cmd_flag, want.cmd_flag);
                if (out_item.last_frag_flag !== want.last_frag_flag)
                    flag_mismatch("last_frag_flag", out_item.last_frag_flag,
                                  want.last_frag_flag);
                if (out_item.fragment_start !== want.fragment_start)
                    flag_mismatch("fragment_start", out_item.fragment_start,
                                  want.fragment_start);
                if (out_item.fragment_end !== want.fragment_end)
                    flag_mismatch("fragment_end", out_item.fragment_end, want.fragment_end);
                if (out_item.pdu_end !== want.pdu_end)
                    flag_mismatch("pdu_end", out_item.pdu_end, want.pdu_end);
                if (out_item.error_code !== want.error_code)
                    flag_mismatch("error_code", out_item.error_code, want.error_code);
            end
        end
    end

    // Abandon a run that hangs
    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int sel;
        int cut;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_stall      = 1'b0;
        bytes_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        cycles         = 0;
        send_gap       = 0;
        hold_left      = 0;
        drain_wait     = 1'b0;
        drain_done     = 1'b0;
        long_hold_done = 1'b0;
        parser_clear();

        // Wrong type byte
        unit_bytes = '{8'hFF};
        queue_unit(0);
        // Zero total length
        unit_bytes = '{8'h04, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_unit(5);
        // Empty fragment closing the unit, all control bits set
        unit_bytes = '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06,
                       8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF};
        queue_unit(11);
        // Item length below the minimum
        unit_bytes = '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06,
                       8'h00, 8'h00, 8'h00, 8'h01};
        queue_unit(9);

        // Random units: mostly well-formed, some corrupted or cut short
        while (raw_bytes_q.size() < N_BYTES) begin
            build_unit($urandom_range(1, 3), 40);
            sel = $urandom_range(0, 19);
            case (sel)
                0: unit_bytes[0] = 8'($urandom);
                1: set_word(6, 32'($urandom_range(0, 1)));
                2: set_word(6, 32'($urandom));
                3: set_word(2, 32'(unit_bytes.size() - 6 - $urandom_range(1, 8)));
                4: set_word(2, 32'(unit_bytes.size() - 6 + $urandom_range(1, 9)));
                5: set_word(2, 32'hFFFF_FFFF);
                6: unit_bytes[$urandom_range(0, unit_bytes.size() - 1)] = 8'($urandom);
                default: ;
            endcase
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                cut = unit_bytes.size() - 1;
            end else if (sel < 8) begin
                // Trailing junk after the unit, ignored up to the last byte
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
                cut = unit_bytes.size() - 1;
            end else if (sel == 8) begin
                cut = $urandom_range(0, unit_bytes.size() - 1);
            end else begin
                cut = -1;
            end
            queue_unit(cut);
        end
        byte_total = raw_bytes_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_sent < byte_total)
            @(posedge i_clk);
        while (expected_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pdd_pkg.sv
rtl/pdd_in_reg.sv
rtl/pdd_parser.sv
rtl/pdd_out_reg.sv
rtl/pdata_pdu_deframer.sv
test/tb_top.sv
